FILE: design/fp32_fp6_e3m2_converter_macros.svh
// Assertion macros used by the converter's top-level design file.
`ifndef FP32_FP6_E3M2_CONVERTER_MACROS_SVH
`define FP32_FP6_E3M2_CONVERTER_MACROS_SVH

// Same-cycle implication, checked on clk and disabled during reset.
`define FP6CV_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and disabled during reset.
`define FP6CV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/fp6cv_pkg.sv
// Types and constants for the FP32 / E3M2 converter pipeline.
package fp6cv_pkg;

  // Request direction codes.
  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  // Exponent biases of the two formats.
  localparam int FP32_BIAS = 127;
  localparam int E3M2_BIAS = 3;

  // Field constants.
  localparam logic [7:0] FP32_EXP_ALL_ONES = 8'hFF;
  localparam logic [7:0] FP32_EXP_ZERO = 8'h00;
  localparam logic [4:0] E3M2_MAX_MAG = 5'h1F;

  // Rebiased exponent limits, E3M2 biased scale.
  localparam logic signed [9:0] E3M2_EXP_OVF = 10'sd8;
  localparam logic signed [9:0] E3M2_EXP_SUB_MIN = -10'sd2;
  localparam logic signed [9:0] E3M2_EXP_ZERO = 10'sd0;

  // Input word.
  typedef struct packed {
    logic        req_type;
    logic [31:0] fp32_in;
    logic [5:0]  fp6_in;
  } req_t;

  // After unpack: classification, rebiased exponent and round decision.
  typedef struct packed {
    logic               req_type;
    logic               special;
    logic [5:0]         special_val;
    logic               sign;
    logic signed [9:0]  exp;
    logic [1:0]         man;
    logic               rnd_up;
    logic [5:0]         fp6_in;
  } unpack_t;

  // After rounding; decode result is already formed.
  typedef struct packed {
    logic               req_type;
    logic               special;
    logic [5:0]         special_val;
    logic               sign;
    logic signed [9:0]  exp;
    logic [1:0]         man;
    logic [31:0]        fp32_dec;
  } round_t;

  // Output word.
  typedef struct packed {
    logic [5:0]  fp6_out;
    logic [31:0] fp32_out;
  } rsp_t;

endpackage

FILE: design/fp6cv_req_if.sv
// Request channel interface: valid/ready handshake with the request fields.
interface fp6cv_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] fp32_in;
  logic [5:0]  fp6_in;

  modport source (output valid, output req_type, output fp32_in, output fp6_in, input ready);
  modport sink (input valid, input req_type, input fp32_in, input fp6_in, output ready);
endinterface

FILE: design/fp6cv_rsp_if.sv
// Result channel interface: valid/ready handshake with the result fields.
interface fp6cv_rsp_if;
  logic        valid;
  logic        ready;
  logic [5:0]  fp6_out;
  logic [31:0] fp32_out;

  modport source (output valid, output fp6_out, output fp32_out, input ready);
  modport sink (input valid, input fp6_out, input fp32_out, output ready);
endinterface

FILE: design/fp6cv_unpack.sv
// Stage one: splits the FP32 word, flags special cases and decides rounding.
module fp6cv_unpack (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fp6cv_pkg::req_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fp6cv_pkg::unpack_t out_data
);
  import fp6cv_pkg::*;

  logic        sign;
  logic [7:0]  bexp;
  logic [22:0] frac;
  unpack_t     data_next;

  // Field split and classification.
  always_comb begin
    sign = in_data.fp32_in[31];
    bexp = in_data.fp32_in[30:23];
    frac = in_data.fp32_in[22:0];

    data_next = '0;
    data_next.req_type = in_data.req_type;
    data_next.fp6_in = in_data.fp6_in;
    data_next.sign = sign;
    data_next.exp = 10'(bexp) - 10'(FP32_BIAS - E3M2_BIAS);
    data_next.man = frac[22:21];
    // Round to nearest, ties to even, on the two kept mantissa bits.
    data_next.rnd_up = frac[20] && ((frac[19:0] != 20'd0) || frac[21]);

    if (bexp == FP32_EXP_ALL_ONES) begin
      data_next.special = 1'b1;
      if (frac != 23'd0) begin
        data_next.special_val = {1'b0, E3M2_MAX_MAG};
      end else begin
        data_next.special_val = {sign, E3M2_MAX_MAG};
      end
    end else if (bexp == FP32_EXP_ZERO) begin
      data_next.special = 1'b1;
      data_next.special_val = {sign, 5'd0};
    end
  end

  // Pipeline register.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end
endmodule

FILE: design/fp6cv_round.sv
// Stage two: applies the rounding increment and expands the E3M2 decode word.
module fp6cv_round (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fp6cv_pkg::unpack_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fp6cv_pkg::round_t  out_data
);
  import fp6cv_pkg::*;

  logic [2:0] man_sum;
  logic       d_sign;
  logic [2:0] d_exp;
  logic [1:0] d_man;
  logic [7:0] fexp;
  logic [22:0] fman;
  round_t     data_next;

  always_comb begin
    data_next = '0;
    data_next.req_type = in_data.req_type;
    data_next.special = in_data.special;
    data_next.special_val = in_data.special_val;
    data_next.sign = in_data.sign;

    // Mantissa increment; a carry out moves into the exponent.
    man_sum = {1'b0, in_data.man} + 3'(in_data.rnd_up);
    if (man_sum[2]) begin
      data_next.man = 2'd0;
      data_next.exp = in_data.exp + 10'sd1;
    end else begin
      data_next.man = man_sum[1:0];
      data_next.exp = in_data.exp;
    end

    // Exact decode: subnormals are normalized into FP32 normals.
    d_sign = in_data.fp6_in[5];
    d_exp = in_data.fp6_in[4:2];
    d_man = in_data.fp6_in[1:0];
    if (d_exp == 3'd0) begin
      if (d_man == 2'd1) begin
        fexp = 8'(FP32_BIAS - E3M2_BIAS - 1);
        fman = 23'd0;
      end else begin
        fexp = 8'(FP32_BIAS - E3M2_BIAS);
        fman = {d_man[0], 22'd0};
      end
    end else begin
      fexp = 8'(FP32_BIAS - E3M2_BIAS) + 8'(d_exp);
      fman = {d_man, 21'd0};
    end
    if (in_data.fp6_in[4:0] == 5'd0) begin
      data_next.fp32_dec = {d_sign, 31'd0};
    end else begin
      data_next.fp32_dec = {d_sign, fexp, fman};
    end
  end

  // Pipeline register.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end
endmodule

FILE: design/fp6cv_pack.sv
// Stage three: range handling, subnormal shift and packing of the result word.
module fp6cv_pack (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fp6cv_pkg::round_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fp6cv_pkg::rsp_t   out_data
);
  import fp6cv_pkg::*;

  logic [1:0] shamt;
  logic [2:0] man_full;
  logic [5:0] enc;
  rsp_t       data_next;

  always_comb begin
    // Right shift of 1.mm by one minus the exponent for subnormal results.
    shamt = 2'd1 - in_data.exp[1:0];
    man_full = {1'b1, in_data.man};

    if (in_data.special) begin
      enc = in_data.special_val;
    end else if (in_data.exp >= E3M2_EXP_OVF) begin
      enc = {in_data.sign, E3M2_MAX_MAG};
    end else if (in_data.exp < E3M2_EXP_SUB_MIN) begin
      enc = {in_data.sign, 5'd0};
    end else if (in_data.exp <= E3M2_EXP_ZERO) begin
      enc = {in_data.sign, 3'd0, 2'(man_full >> shamt)};
    end else begin
      enc = {in_data.sign, in_data.exp[2:0], in_data.man};
    end

    data_next = '0;
    if (in_data.req_type == REQ_DECODE) begin
      data_next.fp32_out = in_data.fp32_dec;
    end else begin
      data_next.fp6_out = enc;
    end
  end

  // Output register.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end
endmodule

FILE: design/fp32_fp6_e3m2_converter.sv
// Top level of the FP32 / OCP MX E3M2 converter: three-stage elastic pipeline.
//
// Converts one word per clock while rsp accepts, in either direction, chosen per
// word by req_type: encode rounds an FP32 pattern to E3M2 (nearest even,
// saturating, subnormal results truncated, no NaN or infinity in the target),
// decode expands an E3M2 pattern exactly into FP32. A word accepted on req
// passes the unpack, round and output registers before it is valid on rsp. The
// three register stages are unpack and round decision, rounding increment (and
// decode), then range handling and the output register. Throughput is one word
// per cycle; each stage holds its word under backpressure and accepts a new one as
// soon as its own register frees up. The unused result field of each word is zero.
`include "fp32_fp6_e3m2_converter_macros.svh"

module fp32_fp6_e3m2_converter (
  input logic        clk,
  input logic        rst,
  fp6cv_req_if.sink   req,
  fp6cv_rsp_if.source rsp
);
  import fp6cv_pkg::*;

  req_t    req_word;
  unpack_t s1_data;
  round_t  s2_data;
  rsp_t    s3_data;
  logic    s1_valid;
  logic    s1_ready;
  logic    s2_valid;
  logic    s2_ready;

  assign req_word.req_type = req.req_type;
  assign req_word.fp32_in = req.fp32_in;
  assign req_word.fp6_in = req.fp6_in;

  // Stage one: unpack and classify.
  fp6cv_unpack u_unpack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_data   (req_word),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  // Stage two: rounding and decode.
  fp6cv_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  // Stage three: pack into the output register.
  fp6cv_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (s3_data)
  );

  assign rsp.fp6_out = s3_data.fp6_out;
  assign rsp.fp32_out = s3_data.fp32_out;

  // Checks on the pipeline and the result encoding.
  `FP6CV_ASSERT_SAME(a_one_field_used, rsp.valid && (rsp.fp6_out != 6'd0), rsp.fp32_out == 32'd0, "both result fields nonzero")
  `FP6CV_ASSERT_SAME(a_decode_finite, rsp.valid, rsp.fp32_out[30:23] != FP32_EXP_ALL_ONES, "decode gave NaN or infinity")
  `FP6CV_ASSERT_NEXT(a_mid_stage_holds, s2_valid && !s2_ready, s2_valid, "stalled middle stage lost its word")
  `FP6CV_ASSERT_NEXT(a_first_stage_holds, s1_valid && !s1_ready, s1_valid, "stalled first stage lost its word")

endmodule

FILE: tb/tb_fp32_fp6_e3m2_converter.sv
// Self-checking testbench for the FP32 / E3M2 converter, with its own conversion predictor.
`timescale 1ns / 100ps

module tb_fp32_fp6_e3m2_converter;
  import fp6cv_pkg::*;

  logic clk;
  logic rst;

  fp6cv_req_if req_ch ();
  fp6cv_rsp_if rsp_ch ();

  fp32_fp6_e3m2_converter dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Predicted result words, oldest first.
  rsp_t predicted_rsp[$];
  rsp_t want_rsp;
  int   mismatch_count;

  // Idle controls shared by the sender, the receiver and the test tasks.
  int tx_gap_max;
  int rx_stall_max;
  int rx_hold_cycles;

  // Free-running clock, 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard limit on the length of the run.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Round an FP32 pattern to E3M2: nearest even, saturate, subnormals by truncation.
  function automatic logic [5:0] e3m2_encode(logic [31:0] x);
    logic        s;
    logic [7:0]  bexp;
    logic [22:0] frac;
    int          e;
    logic [2:0]  m;
    s    = x[31];
    bexp = x[30:23];
    frac = x[22:0];
    if (bexp == FP32_EXP_ALL_ONES) begin
      return (frac != 0) ? {1'b0, E3M2_MAX_MAG} : {s, E3M2_MAX_MAG};
    end
    if (bexp == FP32_EXP_ZERO) begin
      return {s, 5'b0};
    end
    e = int'(bexp) - FP32_BIAS + E3M2_BIAS;
    m = {1'b0, frac[22:21]};
    // Round bit set and either sticky bits or an odd kept mantissa.
    if (frac[20] && (frac[19:0] != 0 || m[0])) begin
      m = m + 3'd1;
      if (m > 3'd3) begin
        m = 3'd0;
        e = e + 1;
      end
    end
    if (e <= 0) begin
      if (e < -2) begin
        return {s, 5'b0};
      end
      m = (m | 3'b100) >> (1 - e);
      return {s, 3'b000, m[1:0]};
    end
    if (e >= 8) begin
      return {s, E3M2_MAX_MAG};
    end
    return {s, e[2:0], m[1:0]};
  endfunction

  // Expand an E3M2 pattern exactly into FP32, normalizing subnormals.
  function automatic logic [31:0] e3m2_decode(logic [5:0] v);
    logic [2:0]  ex;
    logic [1:0]  m;
    logic [7:0]  fexp;
    logic [22:0] fman;
    if (v[4:0] == 5'b0) begin
      return {v[5], 31'b0};
    end
    ex = v[4:2];
    m  = v[1:0];
    if (ex == 3'd0) begin
      if (m == 2'd1) begin
        fexp = 8'(FP32_BIAS - 4);
        fman = '0;
      end else begin
        fexp = 8'(FP32_BIAS - 3);
        fman = {m[0], 22'b0};
      end
    end else begin
      fexp = 8'(int'(ex) - E3M2_BIAS + FP32_BIAS);
      fman = {m, 21'b0};
    end
    return {v[5], fexp, fman};
  endfunction

  // Full result word for one request; the unused field is zero.
  function automatic rsp_t convert_word(req_t w);
    rsp_t r;
    if (w.req_type == REQ_ENCODE) begin
      r.fp6_out  = e3m2_encode(w.fp32_in);
      r.fp32_out = '0;
    end else begin
      r.fp6_out  = '0;
      r.fp32_out = e3m2_decode(w.fp6_in);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Offer one word after a random gap and hold it until accepted.
  task automatic send_word(input logic rt, input logic [31:0] f32, input logic [5:0] f6);
    req_t w;
    int   gap;
    w.req_type = rt;
    w.fp32_in  = f32;
    w.fp6_in   = f6;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= w.req_type;
    req_ch.fp32_in  <= w.fp32_in;
    req_ch.fp6_in   <= w.fp6_in;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    predicted_rsp.push_back(convert_word(w));
  endtask

  task automatic send_encode(input logic [31:0] f32);
    send_word(REQ_ENCODE, f32, 6'($urandom()));
  endtask

  task automatic send_decode(input logic [5:0] f6);
    send_word(REQ_DECODE, $urandom(), f6);
  endtask

  // Stop offering words and wait until every predicted result has come out.
  task automatic wait_results_drained;
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (predicted_rsp.size() != 0);
  endtask

  // Receiver: random stall per word, plus a long hold-off when one is requested.
  initial begin
    int stall;
    int hold;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (rx_hold_cycles > 0) begin
        hold = rx_hold_cycles;
        rx_hold_cycles = 0;
        rsp_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      stall = $urandom_range(0, rx_stall_max);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (rsp_ch.valid !== 1'b1) @(posedge clk);
    end
  end

  // Compare every accepted result word with the oldest prediction.
  always @(posedge clk) begin
    if (rst === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (predicted_rsp.size() == 0) begin
        report_mismatch($sformatf("result word fp6=%h fp32=%h with nothing pending",
                                  rsp_ch.fp6_out, rsp_ch.fp32_out));
      end else begin
        want_rsp = predicted_rsp.pop_front();
        if (rsp_ch.fp6_out !== want_rsp.fp6_out) begin
          report_mismatch($sformatf("fp6_out got %h want %h",
                                    rsp_ch.fp6_out, want_rsp.fp6_out));
        end
        if (rsp_ch.fp32_out !== want_rsp.fp32_out) begin
          report_mismatch($sformatf("fp32_out got %h want %h",
                                    rsp_ch.fp32_out, want_rsp.fp32_out));
        end
      end
    end
  end

  // NaN, infinities, zeros and FP32 subnormals.
  task automatic test_encode_specials;
    send_encode(32'h0000_0000);
    send_encode(32'h8000_0000);
    send_encode(32'h0000_0001);
    send_encode(32'h807F_FFFF);
    send_encode(32'h7F80_0000);
    send_encode(32'hFF80_0000);
    send_encode(32'h7FC0_0000);
    send_encode(32'hFFFF_FFFF);
  endtask

  // Ties to even, rounding carry into the exponent, and saturation.
  task automatic test_encode_rounding;
    send_encode(32'h3F80_0000);
    send_encode(32'h3F90_0000);
    send_encode(32'h3FB0_0000);
    send_encode(32'hBFF0_0000);
    send_encode(32'h41E0_0000);
    send_encode(32'hC1F0_0000);
    send_encode(32'h7F7F_FFFF);
  endtask

  // Subnormal targets, a carry out of the flush range, and flush to zero.
  task automatic test_encode_subnormals;
    send_encode(32'h3E00_0000);
    send_encode(32'hBD80_0000);
    send_encode(32'h3D00_0000);
    send_encode(32'hBCFF_FFFF);
    send_encode(32'h3C80_0000);
  endtask

  // Signed zeros, subnormals, smallest normal and largest magnitudes.
  task automatic test_decode_values;
    send_decode(6'h00);
    send_decode(6'h20);
    send_decode(6'h01);
    send_decode(6'h02);
    send_decode(6'h23);
    send_decode(6'h04);
    send_decode(6'h1F);
    send_decode(6'h3F);
  endtask

  // Mostly encodes near the E3M2 range with frequent ties, plus decodes and noise.
  task automatic send_random_word;
    logic [31:0] f32;
    int          sel;
    f32 = $urandom();
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      send_decode(6'($urandom()));
    end else begin
      if (sel < 8) begin
        f32[30:23] = 8'($urandom_range(120, 133));
        if ($urandom_range(0, 1) == 1) begin
          f32[19:0] = '0;
        end
      end else if (sel == 8) begin
        f32[30:23] = ($urandom_range(0, 1) == 1) ? FP32_EXP_ALL_ONES : FP32_EXP_ZERO;
        if ($urandom_range(0, 1) == 1) begin
          f32[22:0] = '0;
        end
      end
      send_encode(f32);
    end
  endtask

  task automatic test_random_traffic(input int count, input int gap_max, input int stall_max);
    tx_gap_max   = gap_max;
    rx_stall_max = stall_max;
    repeat (count) send_random_word();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering words.
  task automatic test_output_backpressure;
    tx_gap_max     = 0;
    rx_stall_max   = 0;
    rx_hold_cycles = 80;
    repeat (40) send_random_word();
  endtask

  // Sender stops until the pipeline has emptied, several times.
  task automatic test_drain_pauses;
    tx_gap_max   = 2;
    rx_stall_max = 4;
    repeat (6) begin
      repeat ($urandom_range(1, 8)) send_random_word();
      wait_results_drained();
    end
  endtask

  // Main sequence.
  initial begin
    mismatch_count  = 0;
    tx_gap_max      = 4;
    rx_stall_max    = 4;
    rx_hold_cycles  = 0;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_ENCODE;
    req_ch.fp32_in  <= '0;
    req_ch.fp6_in   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_encode_specials();
    test_encode_rounding();
    test_encode_subnormals();
    test_decode_values();
    test_random_traffic(600, 4, 4);
    test_random_traffic(200, 0, 0);
    test_output_backpressure();
    test_drain_pauses();
    test_random_traffic(320, 4, 4);

    // Let everything in flight come out.
    wait_results_drained();
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/fp6cv_pkg.sv
design/fp6cv_req_if.sv
design/fp6cv_rsp_if.sv
design/fp6cv_unpack.sv
design/fp6cv_round.sv
design/fp6cv_pack.sv
design/fp32_fp6_e3m2_converter.sv
tb/tb_fp32_fp6_e3m2_converter.sv
